// ===== rtl/linear_probe_hash_table_core_assert.svh =====
// Assertion macros for the hash table core.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash table core check failed");

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash table core check failed");

`endif

// ===== rtl/lpht_pkg.sv =====
// Shared types, codes and constants of the hash table core.
package lpht_pkg;

  localparam int KEY_W    = 31;
  localparam int SIZE_W   = 5;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [KEY_W-1:0] KEY_EMPTY = 31'd0;
  localparam logic [KEY_W-1:0] KEY_GONE  = 31'd1;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISSING  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RESERVED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_LOAD,
    S_PROBE,
    S_DONE
  } state_t;

  // Remainder unit: start command and finished result.
  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } rem_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } rem_stat_t;

endpackage

// ===== rtl/lpht_rem.sv =====
// Bit-serial remainder unit: key modulo the active table size.
module lpht_rem (
  input  logic                clk,
  input  logic                rst,
  input  lpht_pkg::rem_ctrl_t ctrl,
  output lpht_pkg::rem_stat_t stat
);

  logic                         busy;
  logic                         done;
  logic [lpht_pkg::SIZE_W-1:0]  cnt;
  logic [lpht_pkg::KEY_W-1:0]   dvd;
  logic [lpht_pkg::SIZE_W-1:0]  rem;
  logic [lpht_pkg::SIZE_W:0]    trial;
  logic [lpht_pkg::SIZE_W:0]    dvsr;
  logic [lpht_pkg::SIZE_W:0]    diff;

  // One restoring step: shift in the next key bit, subtract if it fits.
  assign trial = {rem, dvd[lpht_pkg::KEY_W-1]};
  assign dvsr  = {1'b0, ctrl.divisor};
  assign diff  = trial - dvsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= ctrl.dividend;
      rem <= '0;
      cnt <= lpht_pkg::SIZE_W'(lpht_pkg::KEY_W - 1);
    end else if (busy) begin
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
      if (trial >= dvsr) begin
        rem <= diff[lpht_pkg::SIZE_W-1:0];
      end else begin
        rem <= trial[lpht_pkg::SIZE_W-1:0];
      end
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;

endmodule

// ===== rtl/linear_probe_hash_table_core.sv =====
// Top level of the open-addressing hash table with linear probing.
//
//   channel  direction  handshake             payload
//   in       to core    in_valid / in_ready   mode, key
//   out      from core  out_valid / out_ready status, slot
//   cfg      to core    cfg_valid / cfg_ready table_size
//
// An item with a reserved key or an unused mode goes straight to S_DONE, which
// loads its result into the output register; in_ready returns with the result.
// Any other item passes through the bit-serial remainder unit (31 steps and a
// done strobe), one memory read in S_LOAD to prime the probe, one probe per
// cycle after that, and the load of the output register. Probes stop once the
// active size, table_size clamped to one through the table depth, is walked.
// Reset clears every slot to empty at once through per-slot valid bits.
// in_ready is low while an item is in flight and returns with the result; a
// result that waits in the output register holds the block in its last state
// until taken.
`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpht_pkg::MODE_W-1:0]   mode,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpht_pkg::STATUS_W-1:0] status,
  output logic [lpht_pkg::SLOT_W-1:0]   slot,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpht_pkg::SIZE_W-1:0]   table_size
);

  // The size register tops out at 31, so slots beyond that are never probed
  // and get no storage.
  localparam int MEM_DEPTH = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
  localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CNT_W     = lpht_pkg::SIZE_W + 1;

  lpht_pkg::state_t state, state_next;

  // configuration
  logic [lpht_pkg::SIZE_W-1:0] size_cfg;
  logic [lpht_pkg::SIZE_W-1:0] size_act;

  // per-item context
  logic [lpht_pkg::MODE_W-1:0]   cur_mode;
  logic [lpht_pkg::KEY_W-1:0]    cur_key;
  logic [lpht_pkg::SIZE_W-1:0]   asz;
  logic [IDX_W-1:0]              pos;
  logic [IDX_W-1:0]              pos_inc;
  logic [CNT_W-1:0]              pos_p1;
  logic [lpht_pkg::SIZE_W-1:0]   n;
  logic                          last;
  logic [lpht_pkg::STATUS_W-1:0] res_status;
  logic [lpht_pkg::SLOT_W-1:0]   res_slot;

  // slot memory
  logic [lpht_pkg::KEY_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]       mem_valid;
  logic [IDX_W-1:0]           rd_addr;
  logic [lpht_pkg::KEY_W-1:0] rd_data;
  logic                       rd_valid;
  logic                       mem_we;
  logic [lpht_pkg::KEY_W-1:0] mem_wdata;
  logic [lpht_pkg::KEY_W-1:0] probe_key;

  // handshakes and probe decisions
  logic                          in_fire;
  logic                          early;
  logic [lpht_pkg::STATUS_W-1:0] early_status;
  logic                          out_free;
  logic                          probe_end;
  logic [lpht_pkg::STATUS_W-1:0] probe_status;

  lpht_pkg::rem_ctrl_t rem_ctrl;
  lpht_pkg::rem_stat_t rem_stat;

  lpht_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rem_ctrl),
    .stat (rem_stat)
  );

  // ---------------------------------------------------------------------
  // Configuration: always ready, clamp the size when an item is taken.
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= lpht_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg <= table_size;
    end
  end

  always_comb begin
    if (size_cfg == '0) begin
      size_act = lpht_pkg::SIZE_W'(1);
    end else if (size_cfg > lpht_pkg::SIZE_W'(MEM_DEPTH)) begin
      size_act = lpht_pkg::SIZE_W'(MEM_DEPTH);
    end else begin
      size_act = size_cfg;
    end
  end

  // ---------------------------------------------------------------------
  // Request decode: reserved keys and the unused mode skip the probe.
  // ---------------------------------------------------------------------
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    early        = 1'b1;
    early_status = lpht_pkg::STAT_MISSING;
    if (key == lpht_pkg::KEY_EMPTY || key == lpht_pkg::KEY_GONE) begin
      early_status = lpht_pkg::STAT_RESERVED;
    end else if (mode == lpht_pkg::MODE_INSERT || mode == lpht_pkg::MODE_DELETE ||
                 mode == lpht_pkg::MODE_SEARCH) begin
      early = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Probe walk: advance one slot a cycle, wrap at the active size.
  // ---------------------------------------------------------------------
  assign pos_p1    = CNT_W'(pos) + CNT_W'(1);
  assign pos_inc   = (pos_p1 == CNT_W'(asz)) ? '0 : IDX_W'(pos_p1);
  assign last      = (CNT_W'(n) + CNT_W'(1)) == CNT_W'(asz);
  assign probe_key = rd_valid ? rd_data : lpht_pkg::KEY_EMPTY;

  always_comb begin
    probe_end    = 1'b0;
    probe_status = lpht_pkg::STAT_MISSING;
    mem_we       = 1'b0;
    mem_wdata    = cur_key;
    if (state == lpht_pkg::S_PROBE) begin
      if (cur_mode == lpht_pkg::MODE_INSERT) begin
        // take the first empty or deleted slot
        if (probe_key == lpht_pkg::KEY_EMPTY || probe_key == lpht_pkg::KEY_GONE) begin
          probe_end    = 1'b1;
          probe_status = lpht_pkg::STAT_OK;
          mem_we       = 1'b1;
        end else if (last) begin
          probe_end    = 1'b1;
          probe_status = lpht_pkg::STAT_FULL;
        end
      end else begin
        // pass over deleted slots, stop at a match or an empty slot
        if (probe_key == cur_key) begin
          probe_end    = 1'b1;
          probe_status = lpht_pkg::STAT_OK;
          mem_we       = (cur_mode == lpht_pkg::MODE_DELETE);
          mem_wdata    = lpht_pkg::KEY_GONE;
        end else if (probe_key == lpht_pkg::KEY_EMPTY || last) begin
          probe_end = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lpht_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = early ? lpht_pkg::S_DONE : lpht_pkg::S_HASH;
        end
      end
      lpht_pkg::S_HASH: begin
        if (rem_stat.done) begin
          state_next = lpht_pkg::S_LOAD;
        end
      end
      lpht_pkg::S_LOAD: begin
        state_next = lpht_pkg::S_PROBE;
      end
      lpht_pkg::S_PROBE: begin
        if (probe_end) begin
          state_next = lpht_pkg::S_DONE;
        end
      end
      lpht_pkg::S_DONE: begin
        if (out_free) begin
          state_next = lpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lpht_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    rd_addr           = pos;
    rem_ctrl.start    = 1'b0;
    rem_ctrl.dividend = key;
    rem_ctrl.divisor  = asz;
    case (state)
      lpht_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        rem_ctrl.start = in_valid && !early;
      end
      lpht_pkg::S_PROBE: begin
        // prefetch the next slot while checking this one
        rd_addr = pos_inc;
      end
      default: begin
        rd_addr = pos;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Item context and result
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_mode   <= mode;
      cur_key    <= key;
      asz        <= size_act;
      res_status <= early_status;
      res_slot   <= '0;
    end
    if (state == lpht_pkg::S_HASH && rem_stat.done) begin
      pos <= IDX_W'(rem_stat.rem);
      n   <= '0;
    end
    if (state == lpht_pkg::S_PROBE) begin
      pos <= pos_inc;
      n   <= n + 1'b1;
      if (probe_end) begin
        res_status <= probe_status;
        res_slot   <= (probe_status == lpht_pkg::STAT_OK) ? lpht_pkg::SLOT_W'(pos) : '0;
      end
    end
  end

  // Output register: load from the sequencer, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lpht_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lpht_pkg::S_DONE && out_free) begin
      status <= res_status;
      slot   <= res_slot;
    end
  end

  // ---------------------------------------------------------------------
  // Slot memory with registered read; a slot never written reads as empty.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_valid[pos] <= 1'b1;
      end
      rd_valid <= mem_valid[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `LPHT_ASSERT_IMP(a_probe_in_range, state == lpht_pkg::S_PROBE, CNT_W'(n) < CNT_W'(asz))
  `LPHT_ASSERT_IMP(a_rem_done_in_hash, rem_stat.done, state == lpht_pkg::S_HASH)
  `LPHT_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready)
  `LPHT_ASSERT_IMP(a_slot_zero_on_fail, out_valid && status != lpht_pkg::STAT_OK, slot == '0)

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the linear-probe hash table core: directed and random items.
module tb_top;

  localparam int DEPTH = lpht_pkg::TABLE_DEPTH_DEF;
  // Code of the unused mode.
  localparam logic [lpht_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [lpht_pkg::KEY_W-1:0] KEY_TOP = 31'h7FFF_FFFF;

  localparam int PHASE_ITEMS = 165;
  localparam int HOLD_AT = 120;      // accepted-item count that triggers the long stall
  localparam int HOLD_LEN = 400;     // cycles that out_ready stays low during it
  localparam int QUIET_LO = 600;     // window of accepted items with no idling at all
  localparam int QUIET_HI = 900;
  localparam int TAIL_CYCLES = 60;   // longer than the slowest item

  typedef struct {
    logic [lpht_pkg::MODE_W-1:0] op;
    logic [lpht_pkg::KEY_W-1:0]  k;
  } request_t;

  typedef struct packed {
    logic [lpht_pkg::STATUS_W-1:0] st;
    logic [lpht_pkg::SLOT_W-1:0]   sl;
  } verdict_t;

  typedef struct {
    logic [lpht_pkg::MODE_W-1:0] op;
    logic [lpht_pkg::KEY_W-1:0]  k;
    verdict_t                    v;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [lpht_pkg::MODE_W-1:0]   mode = lpht_pkg::MODE_INSERT;
  logic [lpht_pkg::KEY_W-1:0]    key = lpht_pkg::KEY_EMPTY;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [lpht_pkg::STATUS_W-1:0] status;
  logic [lpht_pkg::SLOT_W-1:0]   slot;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lpht_pkg::SIZE_W-1:0]   table_size = lpht_pkg::SIZE_RESET;

  // Shadow copy of the table and of the size register.
  logic [lpht_pkg::KEY_W-1:0]  shadow_slots [DEPTH] = '{default: lpht_pkg::KEY_EMPTY};
  logic [lpht_pkg::SIZE_W-1:0] shadow_size = lpht_pkg::SIZE_RESET;

  request_t req_backlog [$];   // items waiting to be offered
  reply_t   reply_due [$];     // replies owed by the block, oldest first

  int n_taken = 0;             // items accepted so far
  int err_cnt = 0;
  int hold_left = 0;
  logic hold_fired = 1'b0;
  logic quiet;

  assign quiet = (n_taken >= QUIET_LO) && (n_taken < QUIET_HI);

  linear_probe_hash_table_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot       (slot),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .table_size (table_size)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic flag_error(input string msg);
    $display("MISMATCH: %s", msg);
    err_cnt++;
  endtask

  // Apply one request to the shadow table and return the reply it earns.
  // Clamp the size the way the block does: zero acts as one, anything past
  // the depth acts as the depth. Slots beyond the active size are left alone.
  function automatic verdict_t table_probe(input logic [lpht_pkg::MODE_W-1:0] op,
                                           input logic [lpht_pkg::KEY_W-1:0] k);
    int unsigned span;
    int unsigned pos;
    int unsigned n;
    verdict_t r;
    span = 32'(shadow_size);
    if (span == 0) span = 1;
    if (span > DEPTH) span = DEPTH;
    pos = 32'(k) % span;
    r.st = lpht_pkg::STAT_MISSING;
    r.sl = '0;
    if (k == lpht_pkg::KEY_EMPTY || k == lpht_pkg::KEY_GONE) begin
      r.st = lpht_pkg::STAT_RESERVED;
      return r;
    end
    if (op == lpht_pkg::MODE_INSERT) begin
      // Take the first empty or deleted slot; duplicates are not checked.
      r.st = lpht_pkg::STAT_FULL;
      for (n = 0; n < span; n++) begin
        if (shadow_slots[pos] == lpht_pkg::KEY_EMPTY ||
            shadow_slots[pos] == lpht_pkg::KEY_GONE) begin
          shadow_slots[pos] = k;
          r.st = lpht_pkg::STAT_OK;
          r.sl = pos[lpht_pkg::SLOT_W-1:0];
          return r;
        end
        pos = (pos + 1 == span) ? 0 : pos + 1;
      end
    end else if (op == lpht_pkg::MODE_DELETE || op == lpht_pkg::MODE_SEARCH) begin
      // Walk past deleted slots; stop on a match or an empty slot.
      for (n = 0; n < span; n++) begin
        if (shadow_slots[pos] == k) begin
          if (op == lpht_pkg::MODE_DELETE) shadow_slots[pos] = lpht_pkg::KEY_GONE;
          r.st = lpht_pkg::STAT_OK;
          r.sl = pos[lpht_pkg::SLOT_W-1:0];
          return r;
        end
        if (shadow_slots[pos] == lpht_pkg::KEY_EMPTY) break;
        pos = (pos + 1 == span) ? 0 : pos + 1;
      end
    end
    return r;
  endfunction

  // Request driver: hold valid and payload until taken, then advance.
  always @(posedge clk) begin : drive_req
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
        nxt = req_backlog.pop_front();
        in_valid <= 1'b1;
        mode <= nxt.op;
        key <= nxt.k;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver stall: fire once, counted here, while requests keep coming.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && n_taken == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver: drop ready at random, or for the whole stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 9);
    end
  end

  // Monitor: check each reply against the oldest owed one, then predict
  // for a newly taken item, then track size writes.
  always @(posedge clk) begin : watch
    reply_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (reply_due.size() == 0) begin
          flag_error($sformatf("reply with nothing owed: status=%0d slot=%0d", status, slot));
        end else begin
          due = reply_due.pop_front();
          if (status !== due.v.st)
            flag_error($sformatf("status got %0d want %0d (mode %0d key %0h)",
                                 status, due.v.st, due.op, due.k));
          if (slot !== due.v.sl)
            flag_error($sformatf("slot got %0d want %0d (mode %0d key %0h)",
                                 slot, due.v.sl, due.op, due.k));
        end
      end
      if (in_valid && in_ready) begin
        due.op = mode;
        due.k = key;
        due.v = table_probe(mode, key);
        reply_due.push_back(due);
        n_taken <= n_taken + 1;
      end
      if (cfg_valid && cfg_ready) shadow_size = table_size;
    end
  end

  task automatic queue_op(input logic [lpht_pkg::MODE_W-1:0] op,
                          input logic [lpht_pkg::KEY_W-1:0] k);
    request_t r;
    r.op = op;
    r.k = k;
    req_backlog.push_back(r);
  endtask

  // Hold until every item is taken and every reply has come back.
  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || reply_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the size register while the block is idle.
  task automatic apply_size(input logic [lpht_pkg::SIZE_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    table_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random phase: mostly operations on a small key set sized to the table,
  // so inserts collide, fill the table, and searches and deletes find hits;
  // the rest is reserved keys, the unused mode and wild keys.
  task automatic fill_phase(input int n_items, input int span);
    logic [lpht_pkg::KEY_W-1:0] pool [$];
    logic [lpht_pkg::KEY_W-1:0] k;
    int npool;
    int i;
    int r;
    npool = span + int'($urandom_range(6, 1));
    for (i = 0; i < npool; i++) begin
      case ($urandom_range(3))
        0: k = 31'($urandom_range(40, 2));
        1: k = 31'($urandom);
        2: k = 31'(KEY_TOP - $urandom_range(40));
        default: k = 31'(span * $urandom_range(500, 1) + $urandom_range(1));
      endcase
      if (k == lpht_pkg::KEY_EMPTY || k == lpht_pkg::KEY_GONE) k = k + 31'd2;
      pool.push_back(k);
    end
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      k = pool[$urandom_range(pool.size() - 1)];
      if (r < 4)
        queue_op(2'($urandom_range(3)),
                 $urandom_range(1) ? lpht_pkg::KEY_GONE : lpht_pkg::KEY_EMPTY);
      else if (r < 7)
        queue_op(MODE_SPARE, k);
      else if (r < 12)
        queue_op(2'($urandom_range(2)), 31'($urandom));
      else if (r < 47)
        queue_op(lpht_pkg::MODE_INSERT, k);
      else if (r < 70)
        queue_op(lpht_pkg::MODE_DELETE, k);
      else
        queue_op(lpht_pkg::MODE_SEARCH, k);
    end
  endtask

  initial begin : stimulus
    logic [lpht_pkg::SIZE_W-1:0] sizes [10];
    int p;
    int span;
    sizes = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd8, 5'd3, 5'd12, 5'd16};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 16.
    // Reserved keys under every mode, and the unused mode on a normal key.
    queue_op(lpht_pkg::MODE_INSERT, lpht_pkg::KEY_EMPTY);
    queue_op(lpht_pkg::MODE_DELETE, lpht_pkg::KEY_GONE);
    queue_op(lpht_pkg::MODE_SEARCH, lpht_pkg::KEY_EMPTY);
    queue_op(MODE_SPARE, lpht_pkg::KEY_GONE);
    queue_op(MODE_SPARE, 31'd5);
    // Largest key, then a collision chain at home slot 2.
    queue_op(lpht_pkg::MODE_INSERT, KEY_TOP);
    queue_op(lpht_pkg::MODE_INSERT, 31'd2);
    queue_op(lpht_pkg::MODE_INSERT, 31'd18);
    queue_op(lpht_pkg::MODE_INSERT, 31'd34);
    queue_op(lpht_pkg::MODE_SEARCH, 31'd18);
    queue_op(lpht_pkg::MODE_DELETE, 31'd18);
    // Search must walk past the deleted slot; insert must reuse it.
    queue_op(lpht_pkg::MODE_SEARCH, 31'd34);
    queue_op(lpht_pkg::MODE_INSERT, 31'd50);
    queue_op(lpht_pkg::MODE_SEARCH, 31'd18);
    queue_op(lpht_pkg::MODE_DELETE, 31'd99);
    queue_op(lpht_pkg::MODE_SEARCH, KEY_TOP);
    // Home slot 15 is taken, so the probe wraps to slot 0.
    queue_op(lpht_pkg::MODE_INSERT, 31'd31);
    queue_op(lpht_pkg::MODE_SEARCH, 31'd31);
    // Duplicate insert, then delete both copies one at a time.
    queue_op(lpht_pkg::MODE_INSERT, 31'd2);
    queue_op(lpht_pkg::MODE_DELETE, 31'd2);
    queue_op(lpht_pkg::MODE_SEARCH, 31'd2);
    queue_op(lpht_pkg::MODE_DELETE, 31'd2);
    queue_op(lpht_pkg::MODE_SEARCH, 31'd2);
    wait_drained();

    // Random phases over sizes that include zero, one, oversize and all-ones.
    // Slots are not cleared between phases, so stale entries carry over.
    for (p = 0; p < 10; p++) begin
      apply_size(sizes[p]);
      span = int'(sizes[p]);
      if (span == 0) span = 1;
      if (span > DEPTH) span = DEPTH;
      fill_phase(PHASE_ITEMS, span);
      wait_drained();
    end

    // Let any stray reply show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #10000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
